// ===== sv/bef_pkg.sv =====
// bef_pkg: types and constants shared by the bundle entry flag counter
// no dependencies
`timescale 1ns / 1ps

package bef_pkg;

   localparam int MAGIC_LEN        = 8;
   localparam int COUNT_OFFSET     = 12;
   localparam int TABLE_START      = 24;
   localparam int ENTRY_BYTES      = 40;
   localparam int FLAG_WORD_OFFSET = 28;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [7:0] MAGIC_BYTES [MAGIC_LEN] = '{
      8'h56, 8'h4A, 8'h53, 8'h42, 8'h30, 8'h30, 8'h30, 8'h36
   };

   typedef enum logic [1:0] {
      KIND_SKIP,
      KIND_COUNT,
      KIND_TABLE
   } token_kind_type;

   typedef struct packed {
      token_kind_type kind;
      logic [1:0]     count_lane;
      logic [7:0]     data;
      logic           last;
      logic           header_ok;
   } token_type;

endpackage

// ===== sv/bef_if.sv =====
// bef_req_if, bef_rsp_if: valid/ready channels of the bundle entry flag counter
// no dependencies
`timescale 1ns / 1ps

interface bef_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       last;

   modport source (output valid, output stream_byte, output last, input ready);
   modport sink (input valid, input stream_byte, input last, output ready);
endinterface

interface bef_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] match_count;

   modport source (output valid, output match_count, input ready);
   modport sink (input valid, input match_count, output ready);
endinterface

// ===== sv/bef_front.sv =====
// bef_front: tracks byte position and magic, classifies each item into a token
// depends on bef_pkg and bef_req_if
`timescale 1ns / 1ps

module bef_front
   import bef_pkg::*;
#(
   parameter int POSITION_BITS = 40
) (
   input  logic       clock,
   input  logic       reset,
   bef_req_if.sink    req_channel,
   output logic       token_valid,
   output token_type  token,
   input  logic       token_ready
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     magic_good_ff, magic_good_in;
   logic                     accept;
   logic                     magic_next;

   assign req_channel.ready = token_ready;
   assign token_valid       = req_channel.valid;
   assign accept            = req_channel.valid && token_ready;

   always_comb begin
      magic_next = magic_good_ff;
      if (pos_ff < POSITION_BITS'(MAGIC_LEN)) begin
         if (req_channel.stream_byte != MAGIC_BYTES[pos_ff[2:0]]) begin
            magic_next = 1'b0;
         end
      end

      token.data       = req_channel.stream_byte;
      token.last       = req_channel.last;
      token.count_lane = pos_ff[1:0];
      token.header_ok  = magic_next && (pos_ff >= POSITION_BITS'(TABLE_START - 1));
      if (pos_ff >= POSITION_BITS'(COUNT_OFFSET)
          && pos_ff < POSITION_BITS'(COUNT_OFFSET + 4)) begin
         token.kind = KIND_COUNT;
      end else if (pos_ff >= POSITION_BITS'(TABLE_START)) begin
         token.kind = KIND_TABLE;
      end else begin
         token.kind = KIND_SKIP;
      end

      pos_in        = pos_ff;
      magic_good_in = magic_good_ff;
      if (accept) begin
         if (req_channel.last) begin
            pos_in        = '0;
            magic_good_in = 1'b1;
         end else begin
            magic_good_in = magic_next;
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + POSITION_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         magic_good_ff <= 1'b1;
      end else begin
         pos_ff        <= pos_in;
         magic_good_ff <= magic_good_in;
      end
   end

endmodule

// ===== sv/bef_queue.sv =====
// bef_queue: short token queue between front and back
// depends on bef_pkg
`timescale 1ns / 1ps

module bef_queue
   import bef_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  token_type push_token,
   output logic      push_ready,
   output logic      pop_valid,
   output token_type pop_token,
   input  logic      pop_ready
);

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   token_type             slots_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  push, pop;

   assign push_ready = count_ff != COUNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_token  = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                               : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                               : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_token;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + COUNT_BITS'(1))
      else $error("push without pop did not grow queue");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - COUNT_BITS'(1))
      else $error("pop without push did not shrink queue");

endmodule

// ===== sv/bef_back.sv =====
// bef_back: entry count capture, table walk, flag matching and result register
// depends on bef_pkg and bef_rsp_if
`timescale 1ns / 1ps

module bef_back
   import bef_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        token_valid,
   input  token_type   token,
   output logic        token_ready,
   bef_rsp_if.source   rsp_channel
);

   logic [31:0] flag_mask_ff;
   logic [31:0] entry_total_ff, entry_total_in;
   logic [31:0] entry_index_ff, entry_index_in;
   logic [5:0]  offset_ff, offset_in;
   logic [23:0] flag_asm_ff, flag_asm_in;
   logic [31:0] match_ff, match_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_count_ff, rsp_count_in;
   logic        pop;
   logic [31:0] flags;
   logic [5:0]  offset_next;

   assign token_ready             = !token.last || !rsp_valid_ff || rsp_channel.ready;
   assign pop                     = token_valid && token_ready;
   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.match_count = rsp_count_ff;
   assign flags                   = {token.data, flag_asm_ff};
   assign offset_next             = offset_ff + 6'd1;

   always_comb begin
      entry_total_in = entry_total_ff;
      entry_index_in = entry_index_ff;
      offset_in      = offset_ff;
      flag_asm_in    = flag_asm_ff;
      match_in       = match_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_channel.ready;
      rsp_count_in   = rsp_count_ff;

      if (pop) begin
         unique case (token.kind)
            KIND_COUNT: begin
               unique case (token.count_lane)
                  2'd0: entry_total_in[7:0]   = token.data;
                  2'd1: entry_total_in[15:8]  = token.data;
                  2'd2: entry_total_in[23:16] = token.data;
                  2'd3: entry_total_in[31:24] = token.data;
               endcase
            end
            KIND_TABLE: begin
               if (entry_index_ff < entry_total_ff) begin
                  if (offset_ff == 6'(FLAG_WORD_OFFSET)) begin
                     flag_asm_in[7:0] = token.data;
                  end else if (offset_ff == 6'(FLAG_WORD_OFFSET + 1)) begin
                     flag_asm_in[15:8] = token.data;
                  end else if (offset_ff == 6'(FLAG_WORD_OFFSET + 2)) begin
                     flag_asm_in[23:16] = token.data;
                  end else if (offset_ff == 6'(FLAG_WORD_OFFSET + 3)) begin
                     flag_asm_in = '0;
                     if ((flags & flag_mask_ff) != '0) begin
                        match_in = match_ff + 32'd1;
                     end
                  end
                  if (offset_next == 6'(ENTRY_BYTES)) begin
                     offset_in      = '0;
                     entry_index_in = entry_index_ff + 32'd1;
                  end else begin
                     offset_in = offset_next;
                  end
               end
            end
            default: begin
            end
         endcase

         if (token.last) begin
            rsp_valid_in = 1'b1;
            rsp_count_in = (token.header_ok && entry_index_in == entry_total_in) ? match_in
                                                                                 : '0;
            entry_total_in = '0;
            entry_index_in = '0;
            offset_in      = '0;
            flag_asm_in    = '0;
            match_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_mask_ff   <= '0;
         entry_total_ff <= '0;
         entry_index_ff <= '0;
         offset_ff      <= '0;
         flag_asm_ff    <= '0;
         match_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            flag_mask_ff <= csr_wr_data;
         end
         entry_total_ff <= entry_total_in;
         entry_index_ff <= entry_index_in;
         offset_ff      <= offset_in;
         flag_asm_ff    <= flag_asm_in;
         match_ff       <= match_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   a_offset_bound: assert property (@(posedge clock) disable iff (reset)
      offset_ff < 6'(ENTRY_BYTES))
      else $error("entry offset out of range");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      entry_index_ff <= entry_total_ff)
      else $error("entry index passed entry total");

   a_flags_clear: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= 6'(FLAG_WORD_OFFSET) |-> flag_asm_ff == '0)
      else $error("flag bytes held outside flag word");

endmodule

// ===== sv/bundle_entry_flag_counter.sv =====
// bundle_entry_flag_counter: one byte per cycle when not stalled, one match count per file
// a final byte taken into an empty queue passes the queue slot, then the result register, before a valid result
// throughput: one byte per cycle, set by the front position counter and queue
// a stalled result blocks the next final byte; other bytes flow until the queue fills
// reset: synchronous active high, clears the flag mask and all file state
`timescale 1ns / 1ps

module bundle_entry_flag_counter
   import bef_pkg::*;
#(
   parameter int POSITION_BITS = 40
) (
   input  logic        clock,
   input  logic        reset,
   bef_req_if.sink     req_channel,
   bef_rsp_if.source   rsp_channel,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic      push_valid, push_ready;
   token_type push_token;
   logic      pop_valid, pop_ready;
   token_type pop_token;

   bef_front #(.POSITION_BITS(POSITION_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .token_valid (push_valid),
      .token       (push_token),
      .token_ready (push_ready)
   );

   bef_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_token (push_token),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_token  (pop_token),
      .pop_ready  (pop_ready)
   );

   bef_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .token_valid (pop_valid),
      .token       (pop_token),
      .token_ready (pop_ready),
      .rsp_channel (rsp_channel)
   );

endmodule
